// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

    // Depth of the queue between the decoder and the output stage
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0]  LeadMask2 = 8'hE0;
    localparam logic [7:0]  LeadCode2 = 8'hC0;
    localparam logic [7:0]  LeadMask3 = 8'hF0;
    localparam logic [7:0]  LeadCode3 = 8'hE0;
    localparam logic [7:0]  LeadMask4 = 8'hF8;
    localparam logic [7:0]  LeadCode4 = 8'hF0;
    localparam logic [7:0]  AsciiLim  = 8'h80;
    localparam logic [20:0] BmpMax    = 21'h00FFFF;
    localparam logic [20:0] CpMax     = 21'h10FFFF;
    localparam logic [20:0] SuppBase  = 21'h010000;
    localparam logic [15:0] HiSurr    = 16'hD800;
    localparam logic [15:0] LoSurr    = 16'hDC00;

    // What one queue entry turns into at the output
    typedef enum logic [1:0] {
        KIND_END_ONLY,
        KIND_SINGLE,
        KIND_PAIR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] unit_hi;     // single unit, or high surrogate
        logic [15:0] unit_lo;     // low surrogate
        logic        string_done;
    } q_entry_t;

endpackage

// ===== rtl/u8u16_front.sv =====
module u8u16_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                q_push,
    output u8u16_pkg::q_entry_t q_data
);
    import u8u16_pkg::*;

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] accum_reg, accum_next;
    logic        done_cp;
    logic [20:0] cp;
    logic [20:0] supp;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign supp     = cp - SuppBase;

    always_comb
    begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        done_cp      = 1'b0;
        cp           = '0;
        if (pending_reg == 2'd0)
        begin
            if (s_tdata < AsciiLim)
            begin
                cp      = {13'd0, s_tdata};
                done_cp = 1'b1;
            end
            else if ((s_tdata & LeadMask2) == LeadCode2)
            begin
                accum_next   = {16'd0, s_tdata[4:0]};
                pending_next = 2'd1;
            end
            else if ((s_tdata & LeadMask3) == LeadCode3)
            begin
                accum_next   = {17'd0, s_tdata[3:0]};
                pending_next = 2'd2;
            end
            else if ((s_tdata & LeadMask4) == LeadCode4)
            begin
                accum_next   = {18'd0, s_tdata[2:0]};
                pending_next = 2'd3;
            end
        end
        else
        begin
            accum_next   = {accum_reg[14:0], s_tdata[5:0]};
            pending_next = pending_reg - 2'd1;
            if (pending_reg == 2'd1)
            begin
                cp      = accum_next;
                done_cp = 1'b1;
            end
        end
        if (done_cp)
        begin
            accum_next = '0;
        end
        if (s_tlast)
        begin
            pending_next = 2'd0;
            accum_next   = '0;
        end
    end

    always_comb
    begin
        q_data.string_done = s_tlast;
        q_data.unit_hi     = '0;
        q_data.unit_lo     = HiSurr + {6'd0, supp[9:0]} + (LoSurr - HiSurr);
        if (done_cp && cp <= BmpMax)
        begin
            q_data.kind    = KIND_SINGLE;
            q_data.unit_hi = cp[15:0];
        end
        else if (done_cp && cp <= CpMax)
        begin
            q_data.kind    = KIND_PAIR;
            q_data.unit_hi = HiSurr + {6'd0, supp[19:10]};
        end
        else
        begin
            q_data.kind = KIND_END_ONLY;
        end
        q_push = accept && (q_data.kind != KIND_END_ONLY || s_tlast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            accum_reg   <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

// ===== rtl/u8u16_queue.sv =====
module u8u16_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8u16_pkg::q_entry_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output u8u16_pkg::q_entry_t rd_data
);
    import u8u16_pkg::*;

    q_entry_t             slot_reg [QDepth];
    logic [QPtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign full     = (count_reg == QCntW'(QDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCntW'(do_push) - QCntW'(do_pop);
        end
    end

endmodule

// ===== rtl/u8u16_back.sv =====
module u8u16_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  u8u16_pkg::q_entry_t q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import u8u16_pkg::*;

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [15:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;
    logic        last_reg, last_next;
    logic        load;

    assign load     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load)
        begin
            valid_next = q_valid;
            if (q_valid)
            begin
                unique case (q_data.kind)
                    KIND_PAIR:
                    begin
                        // high half first, hold the entry for the low half
                        data_next  = phase_reg ? q_data.unit_lo : q_data.unit_hi;
                        user_next  = {phase_reg, 1'b1};
                        last_next  = phase_reg && q_data.string_done;
                        q_pop      = phase_reg;
                        phase_next = !phase_reg;
                    end
                    KIND_SINGLE:
                    begin
                        data_next = q_data.unit_hi;
                        user_next = 2'b11;
                        last_next = q_data.string_done;
                        q_pop     = 1'b1;
                    end
                    default:
                    begin
                        data_next = '0;
                        user_next = 2'b10;
                        last_next = q_data.string_done;
                        q_pop     = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// Channel   Dir  Beat contents
// s_*       in   tdata[7:0] byte_in, tlast end_of_string
// m_*       out  tdata[15:0] unit, tuser[0] has_unit, tuser[1] last_of_input,
//                tlast string_done
//
// One byte is taken per cycle; the decoder state (pending count and partial
// code point) updates in the cycle the byte is accepted.
// A byte that completes a supplementary code point gives two output beats, so
// the output side runs one beat per cycle and a four-entry queue absorbs pairs.
// s_tready drops only while that queue is full; a stalled m_tready backs it up.
// Reset clears decoder state, queue pointers and the output valid.
module utf8_to_utf16_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] unit
    output logic [1:0]  m_tuser,   // [0] has_unit, [1] last_of_input
    output logic        m_tlast    // string_done
);
    import u8u16_pkg::*;

    q_entry_t push_data, pop_data;
    logic     push, full, pop, pop_valid;

    // Decode bytes and queue an entry for every byte that yields a result
    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (push_data),
        .full     (full),
        .pop      (pop),
        .rd_valid (pop_valid),
        .rd_data  (pop_data)
    );

    // Expand each entry into one or two output beats
    u8u16_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_data   (pop_data),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // One output beat as the sink sees it
    typedef struct packed {
        logic [15:0] unit;
        logic        has_unit;
        logic        last_of_input;
        logic        string_done;
    } utf16_beat_t;

    // One input beat; fixed_exp rows carry their own single expected beat
    typedef struct packed {
        logic [7:0]  data;
        logic        eos;
        logic        fixed_exp;
        logic [15:0] unit;
        logic        has_unit;
        logic        last_of_input;
        logic        string_done;
    } stim_t;

    localparam logic [20:0] MaxBmp       = 21'h00FFFF;
    localparam logic [20:0] MaxCodePoint = 21'h10FFFF;
    localparam logic [20:0] SuppOffset   = 21'h010000;
    localparam logic [15:0] HighSurrBase = 16'hD800;
    localparam logic [15:0] LowSurrBase  = 16'hDC00;

    localparam int RandomItems = 1200;
    localparam int MaxGap      = 13;
    localparam int StallLimit  = 1000;  // cycles with no beat on either side
    localparam int DrainCycles = 40;    // queue depth plus output stage, with margin

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf8_to_utf16_transcoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] byte_in
        .s_tlast  (s_tlast),    // end_of_string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] unit
        .m_tuser  (m_tuser),    // [0] has_unit, [1] last_of_input
        .m_tlast  (m_tlast)     // string_done
    );

    // Decoder state mirrored by the predictor
    logic [1:0]  seq_remaining = 2'd0;
    logic [20:0] partial_cp    = 21'd0;

    stim_t       sent_bytes [$];      // driven, waiting for the input handshake
    utf16_beat_t expected_units [$];  // predicted, waiting for the output handshake

    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;

    // Directed strings. Rows with fixed_exp set carry an expectation that is
    // plain by inspection; the rest go through the predictor.
    stim_t directed_rows [26] = '{
        // single ASCII byte strings, including the zero byte
        '{8'h41, 1'b1, 1'b1, 16'h0041, 1'b1, 1'b1, 1'b1},
        '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1},
        // stray continuation and 11111xxx in lead position: bare end marker
        '{8'h80, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1},
        '{8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1},
        // two-byte sequence
        '{8'hC3, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hA9, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        // four-byte sequence ending the string: surrogate pair, done on low half
        '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h98, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        // highest legal code point
        '{8'hF4, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        // code point above the legal range: no unit at all
        '{8'hF7, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        // overlong lead with an ASCII byte taken as continuation
        '{8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        // sequence cut short mid-way and on the lead itself
        '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h82, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1},
        '{8'hF0, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1},
        // surrogate code point encoded as three bytes, passed through as is
        '{8'hED, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}
    };

    // Advance the mirrored decoder by one byte; return the UTF-16 beats it yields
    function automatic int decode_byte(input logic [7:0] b, input logic eos,
                                       output utf16_beat_t beats [2]);
        logic [20:0] cp;
        logic [20:0] offset_cp;
        logic        complete;
        int          n;
        cp        = 21'd0;
        offset_cp = 21'd0;
        complete  = 1'b0;
        n         = 0;
        beats[0]  = '0;
        beats[1]  = '0;
        if (seq_remaining == 2'd0)
        begin
            if (!b[7])
            begin
                cp       = {13'd0, b};
                complete = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_cp    = {16'd0, b[4:0]};
                seq_remaining = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_cp    = {17'd0, b[3:0]};
                seq_remaining = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial_cp    = {18'd0, b[2:0]};
                seq_remaining = 2'd3;
            end
            // anything else in lead position is dropped
        end
        else
        begin
            // continuation bits are taken unchecked
            partial_cp    = {partial_cp[14:0], b[5:0]};
            seq_remaining = seq_remaining - 2'd1;
            if (seq_remaining == 2'd0)
            begin
                cp       = partial_cp;
                complete = 1'b1;
            end
        end

        if (complete)
        begin
            if (cp <= MaxBmp)
            begin
                beats[0].unit     = cp[15:0];
                beats[0].has_unit = 1'b1;
                n = 1;
            end
            else if (cp <= MaxCodePoint)
            begin
                offset_cp         = cp - SuppOffset;
                beats[0].unit     = HighSurrBase + {6'd0, offset_cp[19:10]};
                beats[0].has_unit = 1'b1;
                beats[1].unit     = LowSurrBase + {6'd0, offset_cp[9:0]};
                beats[1].has_unit = 1'b1;
                n = 2;
            end
            partial_cp = 21'd0;
        end

        if (eos)
        begin
            // end of string always yields a beat, bare marker if nothing else
            if (n == 0)
                n = 1;
            beats[n-1].string_done = 1'b1;
            seq_remaining = 2'd0;
            partial_cp    = 21'd0;
        end

        if (n > 0)
            beats[n-1].last_of_input = 1'b1;
        return n;
    endfunction

    // Append the UTF-8 form of cp in len bytes; overlong forms are allowed
    function automatic void push_utf8(ref logic [7:0] q [$], input logic [20:0] cp,
                                      input int len);
        case (len)
            2:
            begin
                q.push_back({3'b110, cp[10:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                q.push_back({4'b1110, cp[15:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            4:
            begin
                q.push_back({5'b11110, cp[20:18]});
                q.push_back({2'b10, cp[17:12]});
                q.push_back({2'b10, cp[11:6]});
                q.push_back({2'b10, cp[5:0]});
            end
            default:
                q.push_back({1'b0, cp[6:0]});
        endcase
    endfunction

    // Drive one input beat after a random gap and hold it until accepted
    task automatic send_beat(input stim_t item);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sent_bytes.push_back(item);
        s_tvalid <= 1'b1;
        s_tdata  <= item.data;
        s_tlast  <= item.eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Scoreboard: sample both handshakes on the pre-edge values, predict on
    // the input side first so a same-edge output beat finds its expectation.
    always @(posedge clk)
    begin : scoreboard
        utf16_beat_t beats [2];
        utf16_beat_t got;
        utf16_beat_t want;
        stim_t       item;
        int          n;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (s_tvalid && s_tready)
            begin
                if (sent_bytes.size() == 0)
                begin
                    $error("input beat accepted while none was driven");
                    fail_count++;
                end
                else
                begin
                    item = sent_bytes.pop_front();
                    n = decode_byte(item.data, item.eos, beats);
                    if (item.fixed_exp)
                    begin
                        want.unit          = item.unit;
                        want.has_unit      = item.has_unit;
                        want.last_of_input = item.last_of_input;
                        want.string_done   = item.string_done;
                        expected_units.push_back(want);
                    end
                    else
                    begin
                        for (int i = 0; i < n; i++)
                            expected_units.push_back(beats[i]);
                    end
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.unit          = m_tdata;
                got.has_unit      = m_tuser[0];
                got.last_of_input = m_tuser[1];
                got.string_done   = m_tlast;
                if (expected_units.size() == 0)
                begin
                    $error("output beat with no expectation: unit %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (got.unit !== want.unit)
                    begin
                        $error("unit: expected %h, got %h", want.unit, got.unit);
                        fail_count++;
                    end
                    if (got.has_unit !== want.has_unit)
                    begin
                        $error("has_unit: expected %b, got %b", want.has_unit,
                               got.has_unit);
                        fail_count++;
                    end
                    if (got.last_of_input !== want.last_of_input)
                    begin
                        $error("last_of_input: expected %b, got %b", want.last_of_input,
                               got.last_of_input);
                        fail_count++;
                    end
                    if (got.string_done !== want.string_done)
                    begin
                        $error("string_done: expected %b, got %b", want.string_done,
                               got.string_done);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sink: stall a random number of cycles before each beat, with steady
    // stretches where m_tready stays high
    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, MaxGap);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: no beat on either side for too long ends the run
    initial
    begin : watchdog
        while (idle_cycles < StallLimit)
            @(posedge clk);
        $display("utf8_to_utf16_transcoder regression: fail");
        $finish;
    end

    initial
    begin : source
        logic [7:0]  str_bytes [$];
        logic [20:0] cp;
        stim_t       item;
        int          items_sent;
        int          nchars;
        int          kind;
        int          len;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // Random strings: mostly well-formed characters of every length with
        // random content, mixed with unchecked continuations, noise bytes and
        // strings cut off inside a sequence.
        items_sent = 0;
        while (items_sent < RandomItems)
        begin
            str_bytes.delete();
            nchars = $urandom_range(1, 12);
            for (int c = 0; c < nchars; c++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 28)
                    str_bytes.push_back(8'($urandom_range(0, 127)));
                else if (kind < 46)
                    push_utf8(str_bytes, 21'($urandom_range(0, 'h7FF)), 2);
                else if (kind < 64)
                    push_utf8(str_bytes, 21'($urandom_range(0, 'hFFFF)), 3);
                else if (kind < 84)
                begin
                    // mostly supplementary plane, sometimes past the legal top
                    if ($urandom_range(0, 4) != 0)
                        cp = 21'($urandom_range('h10000, 'h10FFFF));
                    else
                        cp = 21'($urandom_range(0, 'h1FFFFF));
                    push_utf8(str_bytes, cp, 4);
                end
                else if (kind < 92)
                begin
                    // proper lead, then arbitrary bytes in continuation slots
                    len = $urandom_range(2, 4);
                    push_utf8(str_bytes, 21'($urandom), len);
                    for (int k = 1; k < len; k++)
                        str_bytes[str_bytes.size() - k] = 8'($urandom_range(0, 255));
                end
                else
                    str_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                // truncate a trailing sequence so the string ends inside it
                len = $urandom_range(2, 4);
                push_utf8(str_bytes, 21'($urandom), len);
                repeat ($urandom_range(1, len - 1))
                    void'(str_bytes.pop_back());
            end

            foreach (str_bytes[i])
            begin
                item           = '0;
                item.data      = str_bytes[i];
                item.eos       = (i == str_bytes.size() - 1);
                item.fixed_exp = 1'b0;
                send_beat(item);
                items_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected beat, then watch for strays
        while (sent_bytes.size() != 0 || expected_units.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0)
            $display("utf8_to_utf16_transcoder regression: pass");
        else
            $display("utf8_to_utf16_transcoder regression: fail");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_transcoder.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
tb/tb.sv
